[src/stt_pkg.sv]
// stt_pkg: sizes, action and status codes and the word that travels along
// the cell chain of the symbol table. No dependencies.
`default_nettype none
package stt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int HEAD_W  = 64;
  localparam int TAIL_W  = 8;
  localparam int VAL_W   = 32;
  localparam int LOC_W   = 6;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_SEARCH = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic                     vld;
    logic [1:0]               action;
    logic [HEAD_W-1:0]        head;
    logic [TAIL_W-1:0]        tail;
    logic signed [VAL_W-1:0]  value;
    logic [CNT_W-1:0]         count;
    logic                     hit;
    logic [LOC_W-1:0]         loc;
    logic signed [VAL_W-1:0]  fval;
  } tok_t;

  function automatic logic [LOC_W-1:0] loc_of(input logic [IDX_W-1:0] idx);
    loc_of = LOC_W'(32'(idx) + 32'd1);
  endfunction

endpackage
`default_nettype wire

[src/stt_cell.sv]
// stt_cell: one table entry and one stage of the lookup chain.
// Depends on stt_pkg.
`default_nettype none
module stt_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [stt_pkg::IDX_W-1:0]   idx_i,
  input  wire stt_pkg::tok_t               tok_i,
  output stt_pkg::tok_t                    tok_o
);

  logic [stt_pkg::HEAD_W-1:0]       head_r;
  logic [stt_pkg::TAIL_W-1:0]       tail_r;
  logic signed [stt_pkg::VAL_W-1:0] value_r;
  stt_pkg::tok_t                    tok_r;
  stt_pkg::tok_t                    tok_nxt;
  logic                             in_use;
  logic                             match;
  logic                             ins_here;

  assign in_use   = stt_pkg::CNT_W'(idx_i) < tok_i.count;
  assign match    = tok_i.vld && !tok_i.hit && in_use &&
                    (head_r == tok_i.head) && (tail_r == tok_i.tail) &&
                    ((tok_i.action == stt_pkg::ACT_MODIFY) ||
                     (tok_i.action == stt_pkg::ACT_SEARCH));
  assign ins_here = tok_i.vld && (tok_i.action == stt_pkg::ACT_INSERT) &&
                    (stt_pkg::CNT_W'(idx_i) == tok_i.count);

  always_comb begin
    tok_nxt = tok_i;
    if (match || ins_here) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.loc = stt_pkg::loc_of(idx_i);
    end
    if (match && (tok_i.action == stt_pkg::ACT_SEARCH)) begin
      tok_nxt.fval = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_here) begin
      head_r <= tok_i.head;
      tail_r <= tok_i.tail;
    end
    if (ins_here || (match && (tok_i.action == stt_pkg::ACT_MODIFY))) begin
      value_r <= tok_i.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.action <= tok_nxt.action;
    tok_r.head   <= tok_nxt.head;
    tok_r.tail   <= tok_nxt.tail;
    tok_r.value  <= tok_nxt.value;
    tok_r.count  <= tok_nxt.count;
    tok_r.hit    <= tok_nxt.hit;
    tok_r.loc    <= tok_nxt.loc;
    tok_r.fval   <= tok_nxt.fval;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

[src/symbol_table_insert_search_update.sv]
// symbol_table_insert_search_update: symbol table built as a chain of entry
// cells that a request word walks through. Depends on stt_pkg, stt_cell.
//
//   channel   ports                                       handshake
//   input     in_action in_name_head in_name_tail         start, busy
//             in_new_value
//   result    out_status out_location out_found_value     out_strobe
//
// a request word enters the first cell when accepted and moves one cell per
// cycle; after the last cell its result is registered and shown on the outputs
// busy stays high from acceptance until the result cycle; the next word may
// be accepted in the cycle the result is shown, so a new request is taken only
// once the last one has left the cell chain
// reset clears the entry count, busy and the chain's valid bits; entry
// contents are not cleared. the receiver cannot stall: results last one cycle
`default_nettype none
module symbol_table_insert_search_update (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_action,
  input  wire logic [stt_pkg::HEAD_W-1:0]        in_name_head,
  input  wire logic [stt_pkg::TAIL_W-1:0]        in_name_tail,
  input  wire logic signed [stt_pkg::VAL_W-1:0]  in_new_value,
  output logic                                   out_strobe,
  output logic [1:0]                             out_status,
  output logic [stt_pkg::LOC_W-1:0]              out_location,
  output logic signed [stt_pkg::VAL_W-1:0]       out_found_value
);

  stt_pkg::tok_t                     chain [0:stt_pkg::ENTRIES];
  logic                              accept;
  logic                              busy_r;
  logic [stt_pkg::CNT_W-1:0]         count_r;
  logic [stt_pkg::CNT_W-1:0]         count_nxt;
  logic                              strobe_r;
  logic [1:0]                        status_r;
  logic [1:0]                        status_nxt;
  logic [stt_pkg::LOC_W-1:0]         loc_r;
  logic signed [stt_pkg::VAL_W-1:0]  fval_r;
  stt_pkg::tok_t                     last;

  assign accept = start && !busy_r;

  always_comb begin
    chain[0].vld    = accept;
    chain[0].action = in_action;
    chain[0].head   = in_name_head;
    chain[0].tail   = in_name_tail;
    chain[0].value  = in_new_value;
    chain[0].count  = count_r;
    chain[0].hit    = 1'b0;
    chain[0].loc    = '0;
    chain[0].fval   = '0;
  end

  for (genvar g = 0; g < stt_pkg::ENTRIES; g++) begin : g_cell
    stt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx_i (stt_pkg::IDX_W'(g)),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign last = chain[stt_pkg::ENTRIES];

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      unique case (in_action)
        stt_pkg::ACT_CLEAR:  count_nxt = '0;
        stt_pkg::ACT_INSERT: begin
          if (count_r < stt_pkg::CNT_W'(stt_pkg::ENTRIES)) begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    unique case (last.action)
      stt_pkg::ACT_CLEAR:  status_nxt = stt_pkg::ST_DONE;
      stt_pkg::ACT_INSERT: status_nxt = last.hit ? stt_pkg::ST_DONE : stt_pkg::ST_FULL;
      default:             status_nxt = last.hit ? stt_pkg::ST_DONE : stt_pkg::ST_MISS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= last.vld;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (last.vld) begin
        busy_r <= 1'b0;
      end
    end
    status_r <= status_nxt;
    loc_r    <= last.loc;
    fval_r   <= last.fval;
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_location    = loc_r;
  assign out_found_value = fval_r;

  // entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stt_pkg::CNT_W'(stt_pkg::ENTRIES))
    else $error("entry count beyond table size");

  // a result only ends a busy period
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(strobe_r) |-> $past(busy_r))
    else $error("result without a request in flight");

  // an accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after accept");

  // a full report only when the table holds every entry
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && (status_r == stt_pkg::ST_FULL)) |->
      (count_r == stt_pkg::CNT_W'(stt_pkg::ENTRIES)))
    else $error("table full reported with free entries");

endmodule
`default_nettype wire
